FILE: hdl/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned NIBBLE_W  = 4;
   localparam int unsigned VALUE_W   = 16;
   localparam int unsigned POS_W     = 3;
   localparam int unsigned STORE_N   = 6;
   localparam int unsigned APB_DATA_W = 32;
   localparam int unsigned APB_ADDR_W = 3;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h02;
   localparam logic [BYTE_W-1:0] STOP_MARKER_RESET  = 8'h03;
   localparam logic [BYTE_W-1:0] PAIR_MASK          = 8'hFF;

   // Frame positions: hunting, then the bytes after the start marker.
   localparam logic [POS_W-1:0] POS_HUNT = 3'd0;
   localparam logic [POS_W-1:0] POS_LAST = 3'd7;

   // Register indexes, taken from paddr bit 2.
   localparam logic REG_START_MARKER = 1'b0;
   localparam logic REG_STOP_MARKER  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_STRAY    = 2'd1,
      STATUS_PAIR_ERR = 2'd2,
      STATUS_STOP_ERR = 2'd3
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/cfr_req_if.sv
`default_nettype none

interface cfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [cfr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/cfr_rsp_if.sv
`default_nettype none

interface cfr_rsp_if;
   logic                          valid;
   logic                          ready;
   cfr_pkg::status_type           status;
   logic [cfr_pkg::NIBBLE_W-1:0]  sender_id;
   logic [cfr_pkg::NIBBLE_W-1:0]  message_code;
   logic [cfr_pkg::VALUE_W-1:0]   payload;

   modport source (output valid, output status, output sender_id, output message_code,
                   output payload, input ready);
   modport sink   (input valid, input status, input sender_id, input message_code,
                   input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/complemented_frame_receiver.sv
// Complemented frame receiver.
// The req_bus channel carries received bus bytes, one per transaction. Eight
// bytes form a frame: start marker, code byte and its complement, value high
// byte and its complement, value low byte and its complement, stop marker.
// The rsp_bus channel carries at most one result transaction per byte: a
// stray report for a byte seen while hunting that is not the start marker,
// or a status for a closed frame (ok, complement check failed, bad stop).
// On ok the result also carries sender id, message code and the 16-bit value.
// The result is registered and appears on rsp_bus in the cycle after byte acceptance.
// Throughput is one byte per cycle while rsp_bus does not stall: a position counter
// and a few byte compares sit between the accepted byte and the result register.
// When the receiver stalls, the held result stays put and req_bus.ready
// is low for as long as that result waits with rsp_bus.ready low.
// Synchronous reset returns the receiver to hunting, drops any pending
// result, and restores the start marker to 0x02 and stop marker to 0x03.
// The APB port holds the start marker at address 0 and the stop marker at
// address 4; writes complete in the access cycle, csr_pready is always high.
`default_nettype none

module complemented_frame_receiver (
   input  wire logic                                clock,
   input  wire logic                                reset,
   cfr_req_if.sink                                  req_bus,
   cfr_rsp_if.source                                rsp_bus,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cfr_pkg::APB_ADDR_W-1:0]      csr_paddr,
   input  wire logic [cfr_pkg::APB_DATA_W-1:0]      csr_pwdata,
   output logic      [cfr_pkg::APB_DATA_W-1:0]      csr_prdata,
   output logic                                     csr_pready
);
   import cfr_pkg::*;

   // Configuration registers.
   logic [BYTE_W-1:0] start_marker_ff;
   logic [BYTE_W-1:0] stop_marker_ff;
   logic              cfg_write;
   logic              reg_sel;

   // Frame state. The stored bytes need no reset: each is written before
   // the frame that reads it can close.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] frame_ff [STORE_N];

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [NIBBLE_W-1:0] sender_id_ff, sender_id_in;
   logic [NIBBLE_W-1:0] message_code_ff, message_code_in;
   logic [VALUE_W-1:0]  payload_ff, payload_in;

   logic accept;
   logic result_new;
   logic pairs_ok;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (reg_sel == REG_STOP_MARKER) begin
         csr_prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, stop_marker_ff};
      end else begin
         csr_prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, start_marker_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         stop_marker_ff  <= STOP_MARKER_RESET;
      end else if (cfg_write) begin
         if (reg_sel == REG_START_MARKER) begin
            start_marker_ff <= csr_pwdata[BYTE_W-1:0];
         end else begin
            stop_marker_ff <= csr_pwdata[BYTE_W-1:0];
         end
      end
   end

   // A new byte is taken whenever the result register is empty or is being
   // emptied in this cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Each pair must be exact complements, that is XOR to all ones.
   assign pairs_ok = ((frame_ff[0] ^ frame_ff[1]) == PAIR_MASK) &&
                     ((frame_ff[2] ^ frame_ff[3]) == PAIR_MASK) &&
                     ((frame_ff[4] ^ frame_ff[5]) == PAIR_MASK);

   always_comb begin
      pos_in          = pos_ff;
      result_new      = 1'b0;
      status_in       = STATUS_OK;
      sender_id_in    = '0;
      message_code_in = '0;
      payload_in      = '0;
      if (accept) begin
         if (pos_ff == POS_HUNT) begin
            if (req_bus.rx_byte == start_marker_ff) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               result_new = 1'b1;
               status_in  = STATUS_STRAY;
            end
         end else if (pos_ff != POS_LAST) begin
            pos_in = pos_ff + POS_W'(1);
         end else begin
            // Eighth byte closes the frame; the stop marker is checked first.
            pos_in     = POS_HUNT;
            result_new = 1'b1;
            if (req_bus.rx_byte != stop_marker_ff) begin
               status_in = STATUS_STOP_ERR;
            end else if (!pairs_ok) begin
               status_in = STATUS_PAIR_ERR;
            end else begin
               status_in       = STATUS_OK;
               sender_id_in    = frame_ff[0][BYTE_W-1:NIBBLE_W];
               message_code_in = frame_ff[0][NIBBLE_W-1:0];
               payload_in      = {frame_ff[2], frame_ff[4]};
            end
         end
      end
   end

   always_comb begin
      if (result_new) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_N; i++) begin
         if (accept && (pos_ff == POS_W'(i + 1))) begin
            frame_ff[i] <= req_bus.rx_byte;
         end
      end
      if (result_new) begin
         status_ff       <= status_in;
         sender_id_ff    <= sender_id_in;
         message_code_ff <= message_code_in;
         payload_ff      <= payload_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.sender_id    = sender_id_ff;
   assign rsp_bus.message_code = message_code_ff;
   assign rsp_bus.payload      = payload_ff;

endmodule

`default_nettype wire

FILE: sim/tb_complemented_frame_receiver.sv
`timescale 1ns / 100ps

module tb_complemented_frame_receiver;
   import cfr_pkg::*;

   // One result transaction as the receiver reports it.
   typedef struct packed {
      status_type            status;
      logic [NIBBLE_W-1:0]   sender_id;
      logic [NIBBLE_W-1:0]   message_code;
      logic [VALUE_W-1:0]    payload;
   } frame_result_type;

   // Tracks the frame reception state of the receiver, predicts the result of
   // every accepted byte and compares the result transactions in order.
   class frame_scoreboard;
      logic [BYTE_W-1:0]  start_mark;
      logic [BYTE_W-1:0]  stop_mark;
      logic [POS_W-1:0]   frame_pos;
      logic [BYTE_W-1:0]  frame_store[STORE_N];
      frame_result_type   expected_q[$];
      int unsigned        mismatch_count;

      function new();
         start_mark     = START_MARKER_RESET;
         stop_mark      = STOP_MARKER_RESET;
         frame_pos      = POS_HUNT;
         mismatch_count = 0;
         foreach (frame_store[i]) frame_store[i] = '0;
      endfunction

      function void write_marker(input logic reg_idx, input logic [BYTE_W-1:0] value);
         if (reg_idx == REG_START_MARKER) begin
            start_mark = value;
         end else begin
            stop_mark = value;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void push_result(input status_type status, input logic [BYTE_W-1:0] code,
                                input logic [VALUE_W-1:0] value);
         frame_result_type res;
         res.status       = status;
         res.sender_id    = code[7:4];
         res.message_code = code[3:0];
         res.payload      = value;
         expected_q.push_back(res);
      endfunction

      function void note_byte(input logic [BYTE_W-1:0] rx);
         if (frame_pos == POS_HUNT) begin
            if (rx == start_mark) begin
               frame_pos = 3'd1;
            end else begin
               push_result(STATUS_STRAY, '0, '0);
            end
         end else if (frame_pos != POS_LAST) begin
            frame_store[frame_pos - 3'd1] = rx;
            frame_pos = frame_pos + 3'd1;
         end else begin
            frame_pos = POS_HUNT;
            if (rx != stop_mark) begin
               push_result(STATUS_STOP_ERR, '0, '0);
            end else if ((frame_store[0] ^ frame_store[1]) != PAIR_MASK ||
                         (frame_store[2] ^ frame_store[3]) != PAIR_MASK ||
                         (frame_store[4] ^ frame_store[5]) != PAIR_MASK) begin
               push_result(STATUS_PAIR_ERR, '0, '0);
            end else begin
               push_result(STATUS_OK, frame_store[0], {frame_store[2], frame_store[4]});
            end
         end
      endfunction

      task report(input string what);
         mismatch_count++;
         $display("%0t ERROR %s", $time, what);
      endtask

      task check_result(input frame_result_type seen);
         frame_result_type exp;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result status %0d", seen.status));
         end else begin
            exp = expected_q.pop_front();
            if (seen.status !== exp.status)
               report($sformatf("status %0d, expected %0d", seen.status, exp.status));
            if (seen.sender_id !== exp.sender_id)
               report($sformatf("sender_id %h, expected %h", seen.sender_id, exp.sender_id));
            if (seen.message_code !== exp.message_code)
               report($sformatf("message_code %h, expected %h", seen.message_code,
                                exp.message_code));
            if (seen.payload !== exp.payload)
               report($sformatf("payload %h, expected %h", seen.payload, exp.payload));
         end
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [APB_ADDR_W-1:0]   paddr;
   logic [APB_DATA_W-1:0]   pwdata;
   logic [APB_DATA_W-1:0]   prdata;
   logic                    pready;

   cfr_req_if req_bus ();
   cfr_rsp_if rsp_bus ();

   frame_scoreboard frames = new();

   // When set, neither side inserts gaps, so back-to-back traffic is covered.
   bit          no_gaps;
   int unsigned bytes_sent;
   int unsigned stall_left;

   complemented_frame_receiver u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (psel),
      .csr_penable (penable),
      .csr_pwrite  (pwrite),
      .csr_paddr   (paddr),
      .csr_pwdata  (pwdata),
      .csr_prdata  (prdata),
      .csr_pready  (pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side stalls. ready is redrawn every cycle; a stall holds it low
   // for a random number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // Monitor both channels at the clock edge. The byte is noted before the
   // result is checked so the order within one edge cannot matter.
   always @(posedge clock) begin
      frame_result_type seen;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) frames.note_byte(req_bus.rx_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status       = rsp_bus.status;
            seen.sender_id    = rsp_bus.sender_id;
            seen.message_code = rsp_bus.message_code;
            seen.payload      = rsp_bus.payload;
            frames.check_result(seen);
         end
      end
   end

   // Offers one byte after a random gap and returns at the edge where the
   // transaction completes. valid stays high when no gap follows.
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= rx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // One frame. A nonzero flip spoils the matching complement byte.
   task automatic send_frame(input logic [BYTE_W-1:0] code, hi, lo,
                             input logic [BYTE_W-1:0] flip0, flip1, flip2,
                             input logic [BYTE_W-1:0] closing);
      send_byte(frames.start_mark);
      send_byte(code);
      send_byte(~code ^ flip0);
      send_byte(hi);
      send_byte(~hi ^ flip1);
      send_byte(lo);
      send_byte(~lo ^ flip2);
      send_byte(closing);
   endtask

   // Stops sending and waits until every predicted result has been taken,
   // then idles on so that a frame in flight has settled too.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (frames.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, then an idle cycle so that the
   // next transfer starts on a fresh edge.
   task automatic apb_write(input logic reg_idx, input logic [BYTE_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= {{(APB_DATA_W-BYTE_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      frames.write_marker(reg_idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // APB read, checked against the marker the scoreboard holds.
   task automatic apb_check(input logic reg_idx);
      logic [BYTE_W-1:0] want;
      want    = (reg_idx == REG_START_MARKER) ? frames.start_mark : frames.stop_mark;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {{(APB_DATA_W-BYTE_W){1'b0}}, want})
         frames.report($sformatf("register %0d reads %h, expected %h", reg_idx, prdata, want));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_markers(input logic [BYTE_W-1:0] start_val, stop_val);
      wait_idle();
      apb_write(REG_START_MARKER, start_val);
      apb_write(REG_STOP_MARKER, stop_val);
      apb_check(REG_START_MARKER);
      apb_check(REG_STOP_MARKER);
   endtask

   // Random traffic. Most of it is well-formed frames with random content so
   // that the receiver gets past the opening states; the rest is damaged
   // frames and stray bytes. Every sequence ends on a frame boundary.
   task automatic random_traffic(input int unsigned count, input bit pause_midway);
      int unsigned       target;
      int unsigned       r;
      int unsigned       which;
      int unsigned       n;
      logic [BYTE_W-1:0] flips[3];
      logic [BYTE_W-1:0] rx;
      bit                paused;
      target = bytes_sent + count;
      paused = 1'b0;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
         if (pause_midway && !paused && bytes_sent >= target - count / 2) begin
            // Hold the sender off until the receiver has delivered everything.
            wait_idle();
            paused = 1'b1;
         end
         flips = '{default: '0};
         r = $urandom_range(0, 99);
         if (r < 60) begin
            send_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)), '0, '0, '0, frames.stop_mark);
         end else if (r < 72) begin
            which = $urandom_range(0, 2);
            flips[which] = BYTE_W'($urandom_range(1, 255));
            send_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)), flips[0], flips[1], flips[2],
                       frames.stop_mark);
         end else if (r < 80) begin
            do rx = BYTE_W'($urandom_range(0, 255)); while (rx == frames.stop_mark);
            send_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)), '0, '0, '0, rx);
         end else if (r < 88) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               do rx = BYTE_W'($urandom_range(0, 255)); while (rx == frames.start_mark);
               send_byte(rx);
            end
         end else begin
            // A start marker followed by seven arbitrary bytes.
            send_byte(frames.start_mark);
            repeat (7) send_byte(BYTE_W'($urandom_range(0, 255)));
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      no_gaps         = 1'b0;
      bytes_sent      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The markers come out of reset at their default values.
      apb_check(REG_START_MARKER);
      apb_check(REG_STOP_MARKER);

      // Directed: a stray byte, a good frame with extreme value bytes, a frame
      // closed by the start marker instead of the stop marker (and carrying
      // the start marker as data), and a frame whose code pair differs but is
      // not an exact complement.
      send_byte(8'h00);
      send_frame(8'hA5, 8'hFF, 8'h00, '0, '0, '0, frames.stop_mark);
      send_frame(8'h02, 8'h12, 8'h34, '0, '0, '0, frames.start_mark);
      send_frame(8'h3C, 8'h00, 8'hFF, 8'h01, '0, '0, frames.stop_mark);
      random_traffic(100, 1'b0);

      // Marker settings: both extremes each way round, equal markers, random.
      set_markers(8'h00, 8'hFF);
      random_traffic(100, 1'b1);
      set_markers(8'hFF, 8'h00);
      random_traffic(100, 1'b0);
      set_markers(8'h5A, 8'h5A);
      random_traffic(100, 1'b0);
      set_markers(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      random_traffic(100, 1'b0);

      wait_idle();
      if (frames.pending() != 0)
         frames.report($sformatf("%0d results never arrived", frames.pending()));
      if (frames.mismatch_count == 0) begin
         $display("complemented_frame_receiver test passed");
      end else begin
         $display("complemented_frame_receiver test failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("complemented_frame_receiver test failed");
      $finish;
   end

endmodule

FILE: complemented_frame_receiver.f
hdl/cfr_pkg.sv
hdl/cfr_req_if.sv
hdl/cfr_rsp_if.sv
hdl/complemented_frame_receiver.sv
sim/tb_complemented_frame_receiver.sv
